// ===== src/tvn_pkg.sv =====
`default_nettype none
package tvn_pkg;

  localparam int MaxOctaves   = 8;
  localparam int MaxExtentLog2 = 12;
  localparam int FracBits     = 16;
  localparam int NumStages    = 14;

  localparam int PeriodW = 14;
  localparam int ProdW   = 26;
  localparam int AccW    = 24;
  localparam int RecipW  = 25;
  localparam int RecipSh = 24;

  localparam logic [31:0] HashMulX    = 32'd374761393;
  localparam logic [31:0] HashMulY    = 32'd668265263;
  localparam logic [31:0] HashMulSeed = 32'd2246822519;
  localparam logic [31:0] HashMulMix  = 32'd1274126177;
  localparam logic [31:0] SeedStep    = 32'd131;

  localparam logic [6:0]  RstBasePeriod  = 7'd8;
  localparam logic [3:0]  RstOctaveCount = 4'd6;
  localparam logic [31:0] RstNoiseSeed   = 32'd1013;
  localparam logic [3:0]  RstExtentLog2  = 4'd10;

  localparam logic [2:0] CfgBasePeriod  = 3'd0;
  localparam logic [2:0] CfgOctaveCount = 3'd1;
  localparam logic [2:0] CfgNoiseSeed   = 3'd2;
  localparam logic [2:0] CfgExtentLog2  = 3'd3;

  // floor(2^24 / (2^k - 1)); zero octaves maps to zero
  function automatic logic [RecipW-1:0] recip(input logic [3:0] k);
    logic [RecipW-1:0] r;
    case (k)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd5592405;
      4'd3:    r = 25'd2396745;
      4'd4:    r = 25'd1118481;
      4'd5:    r = 25'd541200;
      4'd6:    r = 25'd266305;
      4'd7:    r = 25'd132104;
      4'd8:    r = 25'd65793;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/tileable_value_noise_fbm.sv =====
`default_nettype none
// Channel  Dir  Ports                                  Handshake
// in       in   in_pixel_x, in_pixel_y                 in_valid / in_stall
// out      out  out_height                             out_valid / out_stall
// cfg      in   cfg_index, cfg_wdata                   cfg_we
//
// 14 register stages, one texel per cycle while out_stall is low.
// All octaves run in parallel lanes, so a texel can enter every cycle; the
// per-stage multipliers (hash mixing, smoothstep, blends, reciprocal divide)
// set the stage count.
// rst_n (sync, active low) clears stage valid bits and loads register defaults.
// A stall on out holds only stages that are full; bubbles still collapse.
module tileable_value_noise_fbm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_height,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import tvn_pkg::*;

  logic [6:0]  base_period_r;
  logic [3:0]  octave_count_r;
  logic [31:0] noise_seed_r;
  logic [3:0]  extent_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r  <= RstBasePeriod;
      octave_count_r <= RstOctaveCount;
      noise_seed_r   <= RstNoiseSeed;
      extent_log2_r  <= RstExtentLog2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgBasePeriod:  base_period_r  <= cfg_wdata[6:0];
        CfgOctaveCount: octave_count_r <= cfg_wdata[3:0];
        CfgNoiseSeed:   noise_seed_r   <= cfg_wdata;
        CfgExtentLog2:  extent_log2_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic [6:0] bp_eff;
  logic [3:0] k_eff;
  logic [3:0] e_eff;
  logic [11:0] e_mask;

  assign bp_eff = (base_period_r == 7'd0) ? 7'd1 : base_period_r;
  assign k_eff  = (octave_count_r > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octave_count_r;
  always_comb begin
    e_eff = extent_log2_r;
    if (extent_log2_r == 4'd0) e_eff = 4'd1;
    if (extent_log2_r > 4'(MaxExtentLog2)) e_eff = 4'(MaxExtentLog2);
  end
  assign e_mask = 12'((13'd1 << e_eff) - 13'd1);

  // stage valid bits and per-stage load enables
  logic [NumStages:1]   v_r;
  logic [NumStages+1:1] en;

  always_comb begin
    en[NumStages+1] = !out_stall;
    for (int s = NumStages; s >= 1; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int s = 2; s <= NumStages; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NumStages];

  logic [15:0] oct_n [MaxOctaves];

  for (genvar o = 0; o < MaxOctaves; o++) begin : g_oct
    logic [PeriodW-1:0] per;
    logic [31:0]        seed_o;
    assign per    = PeriodW'(bp_eff) << o;
    assign seed_o = noise_seed_r + 32'(o) * SeedStep;

    // stage 1: lattice products of the wrapped coordinate
    logic [ProdW-1:0] px_r, py_r;
    always_ff @(posedge clk) begin
      if (en[1]) begin
        px_r <= ProdW'(in_pixel_x & e_mask) * ProdW'(per);
        py_r <= ProdW'(in_pixel_y & e_mask) * ProdW'(per);
      end
    end

    // stage 2: cells and fractions
    logic [ProdW+15:0] tx, ty;
    logic [PeriodW-1:0] x0_nxt, y0_nxt;
    logic [PeriodW:0]   x0i, y0i;
    logic [PeriodW-1:0] x0_r, x1_r, y0_r, y1_r;
    logic [15:0]        fx_r, fy_r;
    assign tx = {px_r, 16'd0} >> e_eff;
    assign ty = {py_r, 16'd0} >> e_eff;
    assign x0_nxt = tx[16 +: PeriodW];
    assign y0_nxt = ty[16 +: PeriodW];
    assign x0i = {1'b0, x0_nxt} + 1'b1;
    assign y0i = {1'b0, y0_nxt} + 1'b1;
    always_ff @(posedge clk) begin
      if (en[2]) begin
        x0_r <= x0_nxt;
        y0_r <= y0_nxt;
        x1_r <= (x0i == {1'b0, per}) ? '0 : x0i[PeriodW-1:0];
        y1_r <= (y0i == {1'b0, per}) ? '0 : y0i[PeriodW-1:0];
        fx_r <= tx[15:0];
        fy_r <= ty[15:0];
      end
    end

    // stage 3: hash terms, squared fractions
    logic [31:0] hx0_r, hx1_r, hy0_r, hy1_r, hs_r;
    logic [31:0] fxx, fyy;
    logic [15:0] f2x_r, f2y_r;
    logic [17:0] wx_r, wy_r;
    assign fxx = fx_r * fx_r;
    assign fyy = fy_r * fy_r;
    always_ff @(posedge clk) begin
      if (en[3]) begin
        hx0_r <= {18'd0, x0_r} * HashMulX;
        hx1_r <= {18'd0, x1_r} * HashMulX;
        hy0_r <= {18'd0, y0_r} * HashMulY;
        hy1_r <= {18'd0, y1_r} * HashMulY;
        hs_r  <= seed_o * HashMulSeed;
        f2x_r <= fxx[31:16];
        f2y_r <= fyy[31:16];
        wx_r  <= 18'd196608 - {1'b0, fx_r, 1'b0};
        wy_r  <= 18'd196608 - {1'b0, fy_r, 1'b0};
      end
    end

    // stage 4: corner hash sums, smoothstep weights
    logic [3:0][31:0] h_r;
    logic [33:0] sxp, syp;
    logic [17:0] sx4_r, sy4_r;
    assign sxp = f2x_r * wx_r;
    assign syp = f2y_r * wy_r;
    always_ff @(posedge clk) begin
      if (en[4]) begin
        h_r[0] <= hx0_r + hy0_r + hs_r;
        h_r[1] <= hx1_r + hy0_r + hs_r;
        h_r[2] <= hx0_r + hy1_r + hs_r;
        h_r[3] <= hx1_r + hy1_r + hs_r;
        sx4_r  <= sxp[33:16];
        sy4_r  <= syp[33:16];
      end
    end

    // stage 5: mix multiply
    logic [3:0][31:0] m_r;
    logic [17:0] sx5_r, sy5_r;
    always_ff @(posedge clk) begin
      if (en[5]) begin
        for (int c = 0; c < 4; c++) begin
          m_r[c] <= (h_r[c] ^ (h_r[c] >> 13)) * HashMulMix;
        end
        sx5_r <= sx4_r;
        sy5_r <= sy4_r;
      end
    end

    // stage 6: lattice values
    logic [3:0][15:0] lv_r;
    logic [3:0][31:0] mf;
    logic [17:0] sx6_r, sy6_r;
    always_comb begin
      for (int c = 0; c < 4; c++) mf[c] = m_r[c] ^ (m_r[c] >> 16);
    end
    always_ff @(posedge clk) begin
      if (en[6]) begin
        for (int c = 0; c < 4; c++) lv_r[c] <= mf[c][23:8];
        sx6_r <= sx5_r;
        sy6_r <= sy5_r;
      end
    end

    // stage 7: x blend products, a + (b - a) * s
    logic signed [35:0] dx0_r, dx1_r;
    logic [15:0] a0_r, a1_r;
    logic [17:0] sy7_r;
    always_ff @(posedge clk) begin
      if (en[7]) begin
        dx0_r <= $signed({1'b0, lv_r[1]} - {1'b0, lv_r[0]}) * $signed({1'b0, sx6_r});
        dx1_r <= $signed({1'b0, lv_r[3]} - {1'b0, lv_r[2]}) * $signed({1'b0, sx6_r});
        a0_r  <= lv_r[0];
        a1_r  <= lv_r[2];
        sy7_r <= sy6_r;
      end
    end

    // stage 8: x blend sums
    logic signed [35:0] ax_s, bx_s;
    logic [15:0] ax_r, bx_r;
    logic [17:0] sy8_r;
    assign ax_s = $signed({20'd0, a0_r}) + (dx0_r >>> 16);
    assign bx_s = $signed({20'd0, a1_r}) + (dx1_r >>> 16);
    always_ff @(posedge clk) begin
      if (en[8]) begin
        ax_r  <= ax_s[15:0];
        bx_r  <= bx_s[15:0];
        sy8_r <= sy7_r;
      end
    end

    // stage 9: y blend product
    logic signed [35:0] dy_r;
    logic [15:0] ay_r;
    always_ff @(posedge clk) begin
      if (en[9]) begin
        dy_r <= $signed({1'b0, bx_r} - {1'b0, ax_r}) * $signed({1'b0, sy8_r});
        ay_r <= ax_r;
      end
    end

    // stage 10: octave value
    logic signed [35:0] ny_s;
    logic [15:0]        n_r;
    assign ny_s = $signed({20'd0, ay_r}) + (dy_r >>> 16);
    always_ff @(posedge clk) begin
      if (en[10]) n_r <= ny_s[15:0];
    end
    assign oct_n[o] = n_r;
  end

  // stage 11: weighted terms, pair sums
  logic [MaxOctaves-1:0][AccW-1:0] term;
  logic [3:0][AccW-1:0] pair_r;
  always_comb begin
    for (int o = 0; o < MaxOctaves; o++) begin
      if (4'(o) < k_eff) begin
        term[o] = AccW'(oct_n[o]) << (3'(k_eff - 4'd1 - 4'(o)));
      end else begin
        term[o] = '0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int p = 0; p < 4; p++) pair_r[p] <= term[2*p] + term[2*p+1];
    end
  end

  // stage 12: accumulated sum
  logic [AccW-1:0] acc_r;
  always_ff @(posedge clk) begin
    if (en[12]) acc_r <= pair_r[0] + pair_r[1] + pair_r[2] + pair_r[3];
  end

  // stage 13: reciprocal multiply
  logic [AccW+RecipW-1:0] qp_r;
  logic [AccW-1:0]        acc13_r;
  always_ff @(posedge clk) begin
    if (en[13]) begin
      qp_r    <= acc_r * recip(k_eff);
      acc13_r <= acc_r;
    end
  end

  // stage 14: one-step correction and saturation
  logic [RecipW-1:0] qe;
  logic [RecipW-1:0] qc;
  logic [33:0]       qd;
  logic [33:0]       rem;
  logic [8:0]        dv;
  logic [15:0]       q_nxt;
  logic [15:0]       q_r;
  always_comb begin
    qe  = qp_r[RecipSh +: RecipW];
    dv  = 9'((10'd1 << k_eff) - 10'd1);
    qd  = (34'(qe) << k_eff) - 34'(qe);
    rem = 34'(acc13_r) - qd;
    qc  = (rem >= 34'(dv)) ? qe + 1'b1 : qe;
    if (k_eff == 4'd0) q_nxt = '0;
    else if (qc > 25'd65535) q_nxt = 16'hFFFF;
    else q_nxt = qc[15:0];
  end
  always_ff @(posedge clk) begin
    if (en[14]) q_r <= q_nxt;
  end

  assign out_height = q_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[1] && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NumStages-1] && out_valid && out_stall) |=> v_r[NumStages-1])
    else $error("item dropped behind a stalled output");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !in_stall && !v_r[2]) |=> v_r[2])
    else $error("stage 1 item did not move into an empty stage 2");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import tvn_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_height;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CfgBasePeriod;
  logic [31:0] cfg_wdata = '0;

  tileable_value_noise_fbm dut (.*);

  always #5 clk = ~clk;

  logic [6:0]  cur_base_period = RstBasePeriod;
  logic [3:0]  cur_octaves     = RstOctaveCount;
  logic [31:0] cur_seed        = RstNoiseSeed;
  logic [3:0]  cur_extent      = RstExtentLog2;

  logic [15:0] height_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  function automatic logic [31:0] lattice_hash(logic [31:0] ux, logic [31:0] uy,
                                               logic [31:0] seed);
    logic [31:0] h;
    h = ux * HashMulX + uy * HashMulY + seed * HashMulSeed;
    h = (h ^ (h >> 13)) * HashMulMix;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [63:0] lattice_value(logic [31:0] ux, logic [31:0] uy,
                                                logic [31:0] seed);
    logic [31:0] h;
    h = lattice_hash(ux, uy, seed);
    return 64'(h[23:0] >> (24 - FracBits));
  endfunction

  function automatic logic [63:0] smoothstep_q(logic [63:0] f);
    logic [63:0] f2;
    f2 = (f * f) >> FracBits;
    return (f2 * ((64'd3 << FracBits) - 2 * f)) >> FracBits;
  endfunction

  function automatic logic [63:0] lerp_q(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * ((64'd1 << FracBits) - s) + b * s) >> FracBits;
  endfunction

  function automatic logic [63:0] octave_value(logic [11:0] px, logic [11:0] py,
                                               logic [31:0] period, int e,
                                               logic [31:0] seed);
    logic [63:0] tx, ty, sx, sy, a, b;
    logic [31:0] x0, y0, x1, y1;
    tx = ((64'(px) * period) << FracBits) >> e;
    ty = ((64'(py) * period) << FracBits) >> e;
    x0 = 32'((tx >> FracBits) % period);
    y0 = 32'((ty >> FracBits) % period);
    x1 = (x0 + 1) % period;
    y1 = (y0 + 1) % period;
    sx = smoothstep_q(tx & ((64'd1 << FracBits) - 1));
    sy = smoothstep_q(ty & ((64'd1 << FracBits) - 1));
    a = lerp_q(lattice_value(x0, y0, seed), lattice_value(x1, y0, seed), sx);
    b = lerp_q(lattice_value(x0, y1, seed), lattice_value(x1, y1, seed), sx);
    return lerp_q(a, b, sy);
  endfunction

  function automatic logic [15:0] fbm_height(logic [11:0] px, logic [11:0] py);
    logic [31:0] bp;
    int          k, e;
    logic [63:0] acc, q;
    bp = (cur_base_period == 0) ? 32'd1 : 32'(cur_base_period);
    k = (cur_octaves > MaxOctaves) ? MaxOctaves : int'(cur_octaves);
    e = (cur_extent == 0) ? 1 : int'(cur_extent);
    if (e > MaxExtentLog2) e = MaxExtentLog2;
    if (k == 0) return 16'd0;
    acc = 0;
    for (int o = 0; o < k; o++)
      acc += octave_value(px, py, bp << o, e, cur_seed + 32'(o) * SeedStep) << (k - 1 - o);
    q = acc / ((64'd1 << k) - 1);
    q = q >> (FracBits - 16);
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (height_q.size() == 0) begin
        $error("height: unexpected transfer, actual %0d", out_height);
        errors++;
      end else begin
        logic [15:0] exp_h;
        exp_h = height_q.pop_front();
        if (out_height !== exp_h) begin
          $error("height: expected %0d actual %0d", exp_h, out_height);
          errors++;
        end
      end
    end
  end

  task automatic send_texel(logic [11:0] x, logic [11:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    height_q.insert(height_q.size(), fbm_height(x, y));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (height_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CfgBasePeriod:  cur_base_period = value[6:0];
      CfgOctaveCount: cur_octaves     = value[3:0];
      CfgNoiseSeed:   cur_seed        = value;
      CfgExtentLog2:  cur_extent      = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] bp, logic [3:0] k, logic [31:0] seed,
                            logic [3:0] e);
    drain();
    write_reg(CfgBasePeriod, 32'(bp));
    write_reg(CfgOctaveCount, 32'(k));
    write_reg(CfgNoiseSeed, seed);
    write_reg(CfgExtentLog2, 32'(e));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults;
    send_texel(12'd0, 12'd0);
    send_texel(12'd1023, 12'd1023);
    send_texel(12'd4095, 12'd4095);
    send_texel(12'd1024 + 12'd5, 12'd7);
    send_texel(12'd5, 12'd2048 + 12'd7);
    send_texel(12'd127, 12'd128);
  endtask

  task automatic test_config_extremes;
    set_config(7'd0, 4'd1, 32'd0, 4'd0);
    send_texel(12'd0, 12'd1);
    send_texel(12'd1, 12'd4095);
    set_config(7'd1, 4'd0, 32'hFFFF_FFFF, 4'd1);
    send_texel(12'd1, 12'd1);
    set_config(7'd64, 4'd8, 32'hFFFF_FFFF, 4'd12);
    send_texel(12'd4095, 12'd0);
    send_texel(12'd2048, 12'd2047);
    set_config(7'd127, 4'd15, 32'h8000_0000, 4'd15);
    send_texel(12'd4095, 12'd4095);
    send_texel(12'd1365, 12'd2730);
    set_config(7'd3, 4'd8, 32'd1, 4'd2);
    send_texel(12'd3, 12'd2);
    send_texel(12'd7, 12'd4);
  endtask

  task automatic test_random_stream(int n);
    logic [11:0] x, y, lim;
    set_config(7'($urandom_range(127)), 4'($urandom_range(15)), $urandom(),
               4'($urandom_range(15)));
    lim = (cur_extent == 0) ? 12'd1 : (cur_extent >= 12) ? 12'd4095
          : 12'((1 << cur_extent) - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        x = 12'($urandom());
        y = 12'($urandom());
      end else begin
        x = 12'($urandom_range(lim));
        y = 12'($urandom_range(lim));
      end
      send_texel(x, y);
    end
  endtask

  task automatic run_phase(int idle, int stall, int n);
    idle_pct  = idle;
    stall_pct = stall;
    for (int p = 0; p < 3; p++) test_random_stream(n / 3);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    run_phase(0, 0, 240);
    run_phase(68, 0, 180);
    run_phase(0, 68, 180);
    run_phase(6, 6, 150);
    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    while (height_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && height_q.size() == 0) begin
      $display("tileable_value_noise_fbm regression: pass");
    end else begin
      $display("tileable_value_noise_fbm regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tileable_value_noise_fbm regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/tvn_pkg.sv
src/tileable_value_noise_fbm.sv
test/tb.sv
